/* src/lss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack package
// Shared sizes, request and status codes, beat types and sequencer states.
// ----------------------------------------------------------------------------
package lss_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = 7;
   localparam int DATA_W = 32;

   typedef logic [2:0] req_code_type;
   typedef logic [1:0] status_code_type;

   localparam req_code_type REQ_PUSH   = 3'd0;
   localparam req_code_type REQ_POP    = 3'd1;
   localparam req_code_type REQ_SEARCH = 3'd2;
   localparam req_code_type REQ_SORT   = 3'd3;
   localparam req_code_type REQ_DUMP   = 3'd4;

   localparam status_code_type STATUS_OK        = 2'd0;
   localparam status_code_type STATUS_OVERFLOW  = 2'd1;
   localparam status_code_type STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      req_code_type              req_type;
      logic signed [DATA_W-1:0]  operand_value;
   } req_beat_type;

   typedef struct packed {
      status_code_type           status;
      logic                      found;
      logic signed [DATA_W-1:0]  top_value;
      logic                      top_valid;
      logic [CNT_W-1:0]          element_count;
      logic                      is_full;
      logic signed [DATA_W-1:0]  element_value;
      logic                      last;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TOP_RD,
      S_TOP_WAIT,
      S_SCAN,
      S_SCAN_TAIL,
      S_SORT_RD,
      S_SORT_TAIL,
      S_SORT_FIN,
      S_DUMP_RD,
      S_DUMP_WAIT,
      S_EMIT
   } lss_state_type;

endpackage
`default_nettype wire

/* src/lss_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire                                  clock,
   input  wire                                  wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                      wr_data,
   input  wire                                  rd_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* src/lifo_stack_search_sort_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack with search, sort and dump
// Bounded stack of signed words held in one single-port-read RAM.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next is taken once the result of the
// current one sits in the output register. All element reads go through the
// store's single read port, one per cycle. Push and pop give one beat each
// (pop reads the new top from the store when elements remain), a non-empty
// dump gives one beat per element from the top down, and sort makes one bubble
// pass per position, then a top read. Sort leaves the smallest value on top.
// Every result beat reports the top value, the count and the empty and full
// flags after the request.
// ----------------------------------------------------------------------------
module lifo_stack_search_sort_top
   import lss_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_stall,
   input  req_beat_type  req_data,
   output logic          rsp_valid,
   input  wire           rsp_stall,
   output rsp_beat_type  rsp_data
);

   lss_state_type          state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       end_ff, end_in;
   logic [DATA_W-1:0]      top_ff, top_in;
   logic [DATA_W-1:0]      carry_ff, carry_in;
   logic [DATA_W-1:0]      elem_ff, elem_in;
   logic [DATA_W-1:0]      operand_ff, operand_in;
   req_code_type           op_ff, op_in;
   status_code_type        status_ff, status_in;
   logic                   hit_ff, hit_in;
   logic                   last_ff, last_in;
   rsp_beat_type           rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [DATA_W-1:0]      wr_data;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [DATA_W-1:0]      rd_data;

   logic                   req_take;
   logic                   is_full;
   logic [CNT_W-1:0]       count_dec;
   logic [CNT_W-1:0]       ptr_m2;
   logic                   rd_greater;
   logic [DATA_W-1:0]      big_value;
   logic [DATA_W-1:0]      small_value;

   lss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign is_full     = (count_ff == CNT_W'(DEPTH));
   assign count_dec   = count_ff - CNT_W'(1);
   assign ptr_m2      = ptr_ff - CNT_W'(2);
   assign rd_greater  = $signed(rd_data) > $signed(carry_ff);
   assign big_value   = rd_greater ? rd_data : carry_ff;
   assign small_value = rd_greater ? carry_ff : rd_data;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff     <= ptr_in;
      end_ff     <= end_in;
      top_ff     <= top_in;
      carry_ff   <= carry_in;
      elem_ff    <= elem_in;
      operand_ff <= operand_in;
      op_ff      <= op_in;
      status_ff  <= status_in;
      hit_ff     <= hit_in;
      last_ff    <= last_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      top_in       = top_ff;
      carry_in     = carry_ff;
      elem_in      = elem_ff;
      operand_in   = operand_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      hit_in       = hit_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = ptr_m2[ADDR_W-1:0];
      wr_data      = big_value;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in      = req_data.req_type;
               operand_in = req_data.operand_value;
               hit_in     = 1'b0;
               elem_in    = '0;
               last_in    = 1'b1;
               status_in  = STATUS_OK;
               ptr_in     = '0;
               end_in     = count_dec;
               state_in   = S_EMIT;
               unique case (req_data.req_type)
                  REQ_PUSH: begin
                     if (is_full) begin
                        status_in = STATUS_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[ADDR_W-1:0];
                        wr_data  = req_data.operand_value;
                        count_in = count_ff + CNT_W'(1);
                        top_in   = req_data.operand_value;
                     end
                  end
                  REQ_POP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_UNDERFLOW;
                     end else begin
                        count_in = count_dec;
                        if (count_ff > CNT_W'(1)) begin
                           state_in = S_TOP_RD;
                        end
                     end
                  end
                  REQ_SEARCH: begin
                     if (count_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  REQ_SORT: begin
                     if (count_ff > CNT_W'(1)) begin
                        state_in = S_SORT_RD;
                     end
                  end
                  REQ_DUMP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_UNDERFLOW;
                     end else begin
                        ptr_in   = count_dec;
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_TOP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = count_dec[ADDR_W-1:0];
            state_in = S_TOP_WAIT;
         end
         S_TOP_WAIT: begin
            top_in   = rd_data;
            state_in = S_EMIT;
         end
         S_SCAN: begin
            rd_en  = 1'b1;
            ptr_in = ptr_ff + CNT_W'(1);
            if (ptr_ff != '0 && rd_data == operand_ff) begin
               hit_in = 1'b1;
            end
            if (ptr_ff == end_ff) begin
               state_in = S_SCAN_TAIL;
            end
         end
         S_SCAN_TAIL: begin
            if (rd_data == operand_ff) begin
               hit_in = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_SORT_RD: begin
            rd_en  = 1'b1;
            ptr_in = ptr_ff + CNT_W'(1);
            if (ptr_ff == CNT_W'(1)) begin
               carry_in = rd_data;
            end else if (ptr_ff > CNT_W'(1)) begin
               wr_en    = 1'b1;
               carry_in = small_value;
            end
            if (ptr_ff == end_ff) begin
               state_in = S_SORT_TAIL;
            end
         end
         S_SORT_TAIL: begin
            wr_en    = 1'b1;
            carry_in = small_value;
            state_in = S_SORT_FIN;
         end
         S_SORT_FIN: begin
            wr_en   = 1'b1;
            wr_addr = end_ff[ADDR_W-1:0];
            wr_data = carry_ff;
            end_in  = end_ff - CNT_W'(1);
            ptr_in  = '0;
            if (end_ff == CNT_W'(1)) begin
               state_in = S_TOP_RD;
            end else begin
               state_in = S_SORT_RD;
            end
         end
         S_DUMP_RD: begin
            rd_en    = 1'b1;
            state_in = S_DUMP_WAIT;
         end
         S_DUMP_WAIT: begin
            elem_in  = rd_data;
            last_in  = (ptr_ff == '0);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.found          = hit_ff;
               rsp_in.top_value      = (count_ff != '0) ? top_ff : '0;
               rsp_in.top_valid      = (count_ff != '0);
               rsp_in.element_count  = count_ff;
               rsp_in.is_full        = is_full;
               rsp_in.element_value  = elem_ff;
               rsp_in.last           = last_ff;
               if (op_ff == REQ_DUMP && !last_ff) begin
                  ptr_in   = ptr_ff - CNT_W'(1);
                  state_in = S_DUMP_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // check the fill count, the flags of each beat and push bookkeeping
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.top_valid |->
         rsp_data.element_count == '0 && rsp_data.top_value == '0)
      else $error("empty beat reports a top value or count");

   a_full_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_full |-> rsp_data.top_valid)
      else $error("full beat without a top");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.req_type == REQ_PUSH && !is_full |=>
         count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not advance the fill count");

endmodule
`default_nettype wire

/* bench/tb_lifo_stack_search_sort_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack with search, sort and dump - testbench
// Drives push, pop, search, sort, dump and spare requests through the request
// channel. A local stack copy predicts every response beat, and the
// predictions are matched in order against the response channel. Both
// channels idle and stall at random, and there is one stretch of full-rate
// traffic, held only by the stack's own request stall.
// ----------------------------------------------------------------------------
module tb_lifo_stack_search_sort_top
   import lss_pkg::*;
;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int TAIL_CYCLES = 400;
   localparam int RANDOM_BEATS = 125;
   localparam req_code_type REQ_FIRST_SPARE = 3'd5;
   localparam req_code_type REQ_LAST_SPARE  = 3'd7;
   localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_beat_type  req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_beat_type  rsp_data;

   logic signed [DATA_W-1:0] model_store [DEPTH];
   int unsigned  model_fill = 0;
   rsp_beat_type pending_beats [$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           req_idle_pct = 30;
   int           rsp_stall_pct = 30;

   lifo_stack_search_sort_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic rsp_beat_type stack_beat(input status_code_type status,
                                               input logic found,
                                               input logic signed [DATA_W-1:0] elem,
                                               input logic last);
      rsp_beat_type b;
      b.status        = status;
      b.found         = found;
      b.top_value     = (model_fill > 0) ? model_store[model_fill-1] : '0;
      b.top_valid     = (model_fill > 0);
      b.element_count = CNT_W'(model_fill);
      b.is_full       = (model_fill == DEPTH);
      b.element_value = elem;
      b.last          = last;
      return b;
   endfunction

   function automatic void stack_response(input req_beat_type beat);
      logic hit;
      logic signed [DATA_W-1:0] swap_word;
      case (beat.req_type)
         REQ_PUSH: begin
            if (model_fill >= DEPTH) begin
               pending_beats.push_back(stack_beat(STATUS_OVERFLOW, 1'b0, '0, 1'b1));
            end else begin
               model_store[model_fill] = beat.operand_value;
               model_fill++;
               pending_beats.push_back(stack_beat(STATUS_OK, 1'b0, '0, 1'b1));
            end
         end
         REQ_POP: begin
            if (model_fill == 0) begin
               pending_beats.push_back(stack_beat(STATUS_UNDERFLOW, 1'b0, '0, 1'b1));
            end else begin
               model_fill--;
               pending_beats.push_back(stack_beat(STATUS_OK, 1'b0, '0, 1'b1));
            end
         end
         REQ_SEARCH: begin
            hit = 1'b0;
            for (int i = 0; i < model_fill; i++)
               if (model_store[i] == beat.operand_value) hit = 1'b1;
            pending_beats.push_back(stack_beat(STATUS_OK, hit, '0, 1'b1));
         end
         REQ_SORT: begin
            // largest at the bottom, smallest on top
            for (int i = 0; i + 1 < model_fill; i++)
               for (int j = 0; j + 1 < model_fill - i; j++)
                  if (model_store[j] < model_store[j+1]) begin
                     swap_word        = model_store[j];
                     model_store[j]   = model_store[j+1];
                     model_store[j+1] = swap_word;
                  end
            pending_beats.push_back(stack_beat(STATUS_OK, 1'b0, '0, 1'b1));
         end
         REQ_DUMP: begin
            if (model_fill == 0)
               pending_beats.push_back(stack_beat(STATUS_UNDERFLOW, 1'b0, '0, 1'b1));
            else
               for (int i = 0; i < model_fill; i++)
                  pending_beats.push_back(stack_beat(STATUS_OK, 1'b0,
                                                     model_store[model_fill-1-i],
                                                     (i + 1 == model_fill)));
         end
         default: begin
            pending_beats.push_back(stack_beat(STATUS_OK, 1'b0, '0, 1'b1));
         end
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_beat(input rsp_beat_type got);
      rsp_beat_type want;
      if (pending_beats.size() == 0) begin
         flag_mismatch("pending beats", 1, 0);
      end else begin
         want = pending_beats.pop_front();
         if (got.status !== want.status)
            flag_mismatch("status", got.status, want.status);
         if (got.found !== want.found)
            flag_mismatch("found", got.found, want.found);
         if (got.top_value !== want.top_value)
            flag_mismatch("top_value", got.top_value, want.top_value);
         if (got.top_valid !== want.top_valid)
            flag_mismatch("top_valid", got.top_valid, want.top_valid);
         if (got.element_count !== want.element_count)
            flag_mismatch("element_count", got.element_count, want.element_count);
         if (got.is_full !== want.is_full)
            flag_mismatch("is_full", got.is_full, want.is_full);
         if (got.element_value !== want.element_value)
            flag_mismatch("element_value", got.element_value, want.element_value);
         if (got.last !== want.last)
            flag_mismatch("last", got.last, want.last);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) check_beat(rsp_data);
   end

   task automatic send_beat(input req_code_type kind, input logic signed [DATA_W-1:0] value);
      req_beat_type beat;
      beat.req_type      = kind;
      beat.operand_value = value;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      stack_response(beat);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] random_word();
      int small_val;
      small_val = $urandom_range(8);
      case ($urandom_range(5))
         0: return small_val - 4;
         1: return WORD_MIN;
         2: return WORD_MAX;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_stack();
      send_beat(REQ_POP, 0);
      send_beat(REQ_DUMP, 0);
      send_beat(REQ_SEARCH, 0);
      send_beat(REQ_SORT, 0);
      for (int k = REQ_FIRST_SPARE; k <= REQ_LAST_SPARE; k++)
         send_beat(req_code_type'(k), WORD_MIN);
   endtask

   task automatic test_push_extremes();
      send_beat(REQ_PUSH, WORD_MAX);
      send_beat(REQ_PUSH, WORD_MIN);
      send_beat(REQ_PUSH, 0);
      send_beat(REQ_PUSH, -1);
      send_beat(REQ_SEARCH, WORD_MIN);
      send_beat(REQ_SEARCH, 1);
      send_beat(REQ_SORT, 0);
      send_beat(REQ_DUMP, 0);
      repeat (3) send_beat(REQ_POP, 0);
      // sort with a single element
      send_beat(REQ_SORT, 0);
      send_beat(REQ_DUMP, 0);
      send_beat(REQ_POP, 0);
   endtask

   task automatic test_full_stack();
      while (model_fill < DEPTH) send_beat(REQ_PUSH, random_word());
      send_beat(REQ_PUSH, WORD_MAX);
      send_beat(REQ_PUSH, WORD_MIN);
      send_beat(REQ_SEARCH, model_store[0]);
      send_beat(REQ_SORT, 0);
      send_beat(REQ_DUMP, 0);
      send_beat(REQ_SEARCH, WORD_MIN);
      // hold until every response is back
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int unsigned pick;
      int unsigned push_cut;
      int unsigned pop_cut;
      req_code_type kind;
      logic signed [DATA_W-1:0] value;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == 60) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end else if (n == 100) begin
            req_idle_pct  = 30;
            rsp_stall_pct = 30;
         end
         push_cut = ((n / 35) % 2 == 1) ? 50 : 20;
         pop_cut  = ((n / 35) % 2 == 1) ? 65 : 60;
         pick = $urandom_range(99);
         if (pick < push_cut)      kind = REQ_PUSH;
         else if (pick < pop_cut)  kind = REQ_POP;
         else if (pick < 78)       kind = REQ_SEARCH;
         else if (pick < 85)       kind = REQ_SORT;
         else if (pick < 93)       kind = REQ_DUMP;
         else kind = req_code_type'($urandom_range(REQ_FIRST_SPARE, REQ_LAST_SPARE));
         if (kind == REQ_SEARCH && model_fill > 0 && $urandom_range(1) == 1)
            value = model_store[$urandom_range(model_fill - 1)];
         else
            value = random_word();
         send_beat(kind, value);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_stack();
      test_push_extremes();
      test_full_stack();
      test_random_traffic();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* lifo_stack_search_sort_top.f */
src/lss_pkg.sv
src/lss_ram.sv
src/lifo_stack_search_sort_top.sv
bench/tb_lifo_stack_search_sort_top.sv
